// ===== hdl/format_modifier_allow_table_unit_macros.svh =====
// assertion macros for the format/modifier allow table unit
// depends on i_clk and i_rst_n being visible where a macro is used
`ifndef FORMAT_MODIFIER_ALLOW_TABLE_UNIT_MACROS_SVH
`define FORMAT_MODIFIER_ALLOW_TABLE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define FMAT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("fmat check failed");
// next-cycle implication
`define FMAT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("fmat check failed");
`else
`define FMAT_ASSERT_NOW(lbl, ante, cons)
`define FMAT_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== hdl/fmat_pkg.sv =====
// shared types and constants of the format/modifier allow table unit
// no dependencies
package fmat_pkg;

    typedef enum logic [1:0] {
        KIND_QUERY  = 2'd0,
        KIND_DEMOTE = 2'd1,
        KIND_LOAD   = 2'd2,
        KIND_NOP    = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_DECODE,
        ST_REFILL,
        ST_SCAN,
        ST_RESULT
    } t_state;

    typedef struct packed {
        logic [63:0] modifier;
        logic [31:0] fourcc;
    } t_entry;

    // controller to datapath
    typedef struct packed {
        logic in_ready;
        logic clr_scan;
        logic scan_en;
        logic fill_en;
        logic load_wr;
        logic commit;
        logic out_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        t_kind kind;
        logic  is_floor;
        logic  empty;
        logic  scan_done;
        logic  fill_last;
        logic  out_free;
    } t_sts;

    localparam logic [63:0] MOD_LINEAR    = 64'h0;
    localparam logic [63:0] MOD_IMPLICIT  = 64'h00FF_FFFF_FFFF_FFFF;
    localparam int          DEFAULT_COUNT = 8;

    localparam logic [31:0] DEFAULT_FORMATS [4] = '{
        32'h3432_5241, 32'h3432_5258, 32'h3432_4241, 32'h3432_4258
    };

    // default entry: four formats linear, then the same four implicit
    function automatic t_entry default_entry(input logic [2:0] idx);
        t_entry e;
        e.fourcc   = DEFAULT_FORMATS[idx[1:0]];
        e.modifier = idx[2] ? MOD_IMPLICIT : MOD_LINEAR;
        return e;
    endfunction

endpackage

// ===== hdl/fmat_ctrl.sv =====
// controller state machine of the format/modifier allow table unit
// depends on fmat_pkg
module fmat_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  fmat_pkg::t_sts i_sts,
    output fmat_pkg::t_cmd o_cmd
);

    fmat_pkg::t_state r_state;
    fmat_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fmat_pkg::ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fmat_pkg::ST_INIT: begin
                if (i_sts.fill_last) n_state = fmat_pkg::ST_IDLE;
            end
            fmat_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = fmat_pkg::ST_DECODE;
            end
            fmat_pkg::ST_DECODE: begin
                unique case (i_sts.kind)
                    fmat_pkg::KIND_QUERY: begin
                        if (i_sts.is_floor)   n_state = fmat_pkg::ST_RESULT;
                        else if (i_sts.empty) n_state = fmat_pkg::ST_REFILL;
                        else                  n_state = fmat_pkg::ST_SCAN;
                    end
                    fmat_pkg::KIND_DEMOTE: begin
                        n_state = i_sts.is_floor ? fmat_pkg::ST_RESULT : fmat_pkg::ST_SCAN;
                    end
                    default: n_state = fmat_pkg::ST_RESULT;
                endcase
            end
            fmat_pkg::ST_REFILL: begin
                if (i_sts.fill_last) n_state = fmat_pkg::ST_SCAN;
            end
            fmat_pkg::ST_SCAN: begin
                if (i_sts.scan_done) n_state = fmat_pkg::ST_RESULT;
            end
            fmat_pkg::ST_RESULT: begin
                if (i_sts.out_free) n_state = fmat_pkg::ST_IDLE;
            end
            default: n_state = fmat_pkg::ST_INIT;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            fmat_pkg::ST_INIT:   o_cmd.fill_en  = 1'b1;
            fmat_pkg::ST_IDLE:   o_cmd.in_ready = 1'b1;
            fmat_pkg::ST_DECODE: begin
                o_cmd.clr_scan = 1'b1;
                o_cmd.load_wr  = (i_sts.kind == fmat_pkg::KIND_LOAD);
            end
            fmat_pkg::ST_REFILL: o_cmd.fill_en  = 1'b1;
            fmat_pkg::ST_SCAN: begin
                o_cmd.scan_en = 1'b1;
                o_cmd.commit  = i_sts.scan_done;
            end
            fmat_pkg::ST_RESULT: o_cmd.out_load = i_sts.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

// ===== hdl/fmat_dpath.sv =====
// datapath of the format/modifier allow table unit: table memory, scan, result register
// depends on fmat_pkg and the unit macro header
`include "format_modifier_allow_table_unit_macros.svh"
module fmat_dpath #(
    parameter int TABLE_DEPTH = 128
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  fmat_pkg::t_cmd i_cmd,
    output fmat_pkg::t_sts o_sts,
    input  logic           i_in_valid,
    input  logic [103:0]   i_in_data,
    input  logic [1:0]     i_in_user,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic [23:0]    o_out_data
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    fmat_pkg::t_entry mem [TABLE_DEPTH];

    fmat_pkg::t_kind  r_kind;
    logic [31:0]      r_fourcc;
    logic [63:0]      r_mod;
    logic             r_first;
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    r_idx;
    logic [CW-1:0]    r_kept;
    logic [CW-1:0]    r_removed;
    logic             r_hit;
    logic             r_rd_vld;
    fmat_pkg::t_entry r_rd;
    logic             r_out_valid;
    logic [23:0]      r_out_data;

    logic             w_floor;
    logic             w_mod_eq;
    logic             w_issue;
    logic             w_we;
    logic [AW-1:0]    w_waddr;
    fmat_pkg::t_entry w_wdata;
    logic             w_importable;
    logic [CW+15:0]   w_cnt_ext;
    logic [CW+15:0]   w_rem_ext;
    logic [7:0]       w_rem_out;

    assign w_floor  = (r_mod == fmat_pkg::MOD_LINEAR) || (r_mod == fmat_pkg::MOD_IMPLICIT);
    assign w_mod_eq = (r_rd.modifier == r_mod);
    assign w_issue  = i_cmd.scan_en && (r_idx != r_count);

    // single write port: fill, load, or compaction during a demote scan
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_idx[AW-1:0];
        w_wdata = fmat_pkg::default_entry(r_idx[2:0]);
        if (i_cmd.fill_en) begin
            w_we = 1'b1;
        end else if (i_cmd.load_wr) begin
            w_we    = r_first || (r_count != CW'(TABLE_DEPTH));
            w_waddr = r_first ? '0 : r_count[AW-1:0];
            w_wdata = '{modifier: r_mod, fourcc: r_fourcc};
        end else if (r_rd_vld && (r_kind == fmat_pkg::KIND_DEMOTE) && !w_mod_eq) begin
            w_we    = 1'b1;
            w_waddr = r_kept[AW-1:0];
            w_wdata = r_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) mem[w_waddr] <= w_wdata;
        if (w_issue) r_rd <= mem[r_idx[AW-1:0]];
    end

    // captured item
    always_ff @(posedge i_clk) begin
        if (i_cmd.in_ready && i_in_valid) begin
            r_kind   <= fmat_pkg::t_kind'(i_in_user);
            r_fourcc <= i_in_data[31:0];
            r_mod    <= i_in_data[95:32];
            r_first  <= i_in_data[96];
        end
    end

    // scan, fill and count control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_count  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_cmd.clr_scan) begin
                r_idx    <= '0;
                r_kept   <= '0;
                r_removed <= '0;
                r_hit    <= 1'b0;
                r_rd_vld <= 1'b0;
            end else if (i_cmd.fill_en) begin
                if (o_sts.fill_last) begin
                    r_idx   <= '0;
                    r_count <= CW'(fmat_pkg::DEFAULT_COUNT);
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end else begin
                r_rd_vld <= w_issue;
                if (w_issue) r_idx <= r_idx + 1'b1;
                if (r_rd_vld) begin
                    if (r_kind == fmat_pkg::KIND_DEMOTE) begin
                        if (w_mod_eq) r_removed <= r_removed + 1'b1;
                        else          r_kept    <= r_kept + 1'b1;
                    end else if (w_mod_eq && (r_rd.fourcc == r_fourcc)) begin
                        r_hit <= 1'b1;
                    end
                end
            end
            if (i_cmd.load_wr) begin
                if (r_first) r_count <= CW'(1);
                else if (r_count != CW'(TABLE_DEPTH)) r_count <= r_count + 1'b1;
            end
            if (i_cmd.commit && (r_kind == fmat_pkg::KIND_DEMOTE) && (r_removed != '0)) begin
                r_count <= r_kept;
            end
        end
    end

    // result register
    assign w_importable = (r_kind == fmat_pkg::KIND_QUERY) && (w_floor || r_hit);
    assign w_cnt_ext    = {16'h0, r_count};
    assign w_rem_ext    = {16'h0, r_removed};
    assign w_rem_out    = (r_kind == fmat_pkg::KIND_DEMOTE) ? w_rem_ext[7:0] : 8'h0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= {6'h0, (w_rem_out != 8'h0), w_cnt_ext[7:0], w_rem_out, w_importable};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign o_sts.kind      = r_kind;
    assign o_sts.is_floor  = w_floor;
    assign o_sts.empty     = (r_count == '0);
    assign o_sts.scan_done = (r_idx == r_count) && !r_rd_vld;
    assign o_sts.fill_last = (r_idx == CW'(fmat_pkg::DEFAULT_COUNT - 1));
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    `FMAT_ASSERT_NOW(a_count_max, 1'b1, r_count <= CW'(TABLE_DEPTH))
    `FMAT_ASSERT_NOW(a_write_behind_read, r_rd_vld && (r_kind == fmat_pkg::KIND_DEMOTE), r_kept < r_idx)
    `FMAT_ASSERT_NEXT(a_out_loaded, i_cmd.out_load, r_out_valid)
    `FMAT_ASSERT_NEXT(a_full_saturates, i_cmd.load_wr && !r_first && (r_count == CW'(TABLE_DEPTH)), $stable(r_count))

endmodule

// ===== hdl/format_modifier_allow_table_unit.sv =====
// top level of the format/modifier allow table unit
// depends on fmat_pkg, fmat_ctrl, fmat_dpath
//
//  channel | direction | payload
//  s_axis  | in        | tdata: fourcc, modifier, first_entry; tuser: kind
//  m_axis  | out       | tdata: importable, removed_count, entry_count, resend_feedback
//
// after reset the table takes its eight defaults; no word is taken until then
// a word with no scan (load, no-op, linear or implicit modifier) goes from decode
// straight to the result state, which loads the result register
// a scan (other query, demote) reads one entry per cycle through the single read port
// and then loads the result; an empty-table query first refills the eight defaults
// one word at a time; a result that finds the result register full waits for it to drain
module format_modifier_allow_table_unit #(
    parameter int TABLE_DEPTH = 128
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [103:0] s_axis_tdata,  // fourcc[31:0], modifier[95:32], first_entry[96], zeros
    input  logic [1:0]   s_axis_tuser,  // kind[1:0]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [23:0]  m_axis_tdata   // importable[0], removed_count[8:1],
                                        // entry_count[16:9], resend_feedback[17], zeros
);

    fmat_pkg::t_cmd w_cmd;
    fmat_pkg::t_sts w_sts;

    // sequencing of fill, decode, scan and result
    fmat_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // table memory, scan pipeline and result register
    fmat_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_in_valid  (s_axis_tvalid),
        .i_in_data   (s_axis_tdata),
        .i_in_user   (s_axis_tuser),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata)
    );

    assign s_axis_tready = w_cmd.in_ready;

endmodule
